// File: src/datm_pkg.sv
// ----------------------------------------------------------------------------
// datm_pkg
// shared types, constants and helpers of the disk access time model
// ----------------------------------------------------------------------------
package datm_pkg;

	localparam int TRACK_COUNT = 1024;
	localparam int TRACK_W     = 10;
	localparam int TIME_W      = 48;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [TRACK_W-1:0] TRACK_LAST = TRACK_W'(TRACK_COUNT - 1);

	// register indexes
	localparam logic [2:0] REG_ACCEL_TIME  = 3'd0;
	localparam logic [2:0] REG_ACCEL_SPAN  = 3'd1;
	localparam logic [2:0] REG_CRUISE_TIME = 3'd2;
	localparam logic [2:0] REG_SPIN_STOP   = 3'd3;
	localparam logic [2:0] REG_SPIN_START  = 3'd4;
	localparam logic [2:0] REG_ROT_LAT     = 3'd5;
	localparam logic [2:0] REG_BLOCK_TIME  = 3'd6;

	// reset values
	localparam logic [23:0] RST_ACCEL_TIME  = 24'd117965;
	localparam logic [15:0] RST_ACCEL_SPAN  = 16'd6;
	localparam logic [23:0] RST_CRUISE_TIME = 24'd85197;
	localparam logic [39:0] RST_SPIN_STOP   = 40'd131072000;
	localparam logic [31:0] RST_SPIN_START  = 32'd19660800;
	localparam logic [31:0] RST_ROT_LAT     = 32'd9830400;
	localparam logic [23:0] RST_BLOCK_TIME  = 24'd439;

	typedef struct packed {
		logic [23:0] accel_time_per_track;
		logic [15:0] accel_track_span;
		logic [23:0] cruise_time_per_track;
		logic [39:0] spin_stop_time;
		logic [31:0] spin_start_time;
		logic [31:0] rotation_latency;
		logic [23:0] block_transfer_time;
	} cfg_t;

	// classified request, handed from front to back
	typedef struct packed {
		logic [TIME_W-1:0]  start_time;
		logic [15:0]        block_count;
		logic [TRACK_W-1:0] tracks_moved;
		logic [31:0]        seek_time;
		logic [31:0]        acc_plain;
		logic [31:0]        acc_spin;
		logic [TIME_W-1:0]  free_plain;
		logic [TIME_W-1:0]  free_spin;
		logic               lim_ok;
		logic [TIME_W-1:0]  lim;
	} req_t;

	function automatic logic [31:0] sat32(input logic [41:0] v);
		return (v[41:32] != 10'd0) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

endpackage

// File: src/datm_front.sv
// ----------------------------------------------------------------------------
// datm_front
// accepts requests, finds track distance, seek time and both access candidates
// ----------------------------------------------------------------------------
module datm_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  datm_pkg::cfg_t               cfg,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [datm_pkg::TIME_W-1:0]  start_time,
	input  logic [datm_pkg::TRACK_W-1:0] target_track,
	input  logic [15:0]                  block_count,
	output logic                         push,
	output datm_pkg::req_t               push_item,
	input  logic                         full
);
	import datm_pkg::*;

	typedef struct packed {
		logic [TIME_W-1:0]  start_time;
		logic [15:0]        block_count;
		logic [TRACK_W-1:0] moved;
		logic               lim_ok;
		logic [TIME_W-1:0]  lim;
	} carry_t;

	logic [TRACK_W-1:0] head_q;
	logic [TRACK_W-1:0] target_sat;
	logic [TRACK_W-1:0] dist_in;

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic               en_s1, en_s2, en_s3, en_s4, en_s5;
	carry_t             c_s1, c_s2, c_s3, c_s4, c_s5;
	logic               far_s1, far_s2;
	logic [TRACK_W-1:0] extra_s1;
	logic [33:0]        p_near_s2, p_far_s2;
	logic [39:0]        p_span_s2, p_xfer_s2;
	logic [31:0]        seek_s3, seek_s4, seek_s5;
	logic [40:0]        xfer_s3;
	logic [31:0]        acc_a_s4, acc_b_s4, acc_a_s5, acc_b_s5;
	logic [TIME_W-1:0]  free_a_s5, free_b_s5;

	assign target_sat = (target_track > TRACK_LAST) ? TRACK_LAST : target_track;
	assign dist_in    = (head_q > target_sat) ? head_q - target_sat : target_sat - head_q;

	assign en_s5    = !v_s5 || !full;
	assign en_s4    = !v_s4 || en_s5;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign in_stall = !en_s1;
	assign push     = v_s5 && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			v_s3   <= 1'b0;
			v_s4   <= 1'b0;
			v_s5   <= 1'b0;
		end else begin
			if (in_valid && en_s1) begin
				head_q <= target_sat;
			end
			if (en_s1) begin
				v_s1 <= in_valid;
			end
			if (en_s2) begin
				v_s2 <= v_s1;
			end
			if (en_s3) begin
				v_s3 <= v_s2;
			end
			if (en_s4) begin
				v_s4 <= v_s3;
			end
			if (en_s5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			c_s1.start_time  <= start_time;
			c_s1.block_count <= block_count;
			c_s1.moved       <= dist_in;
			c_s1.lim_ok      <= start_time > {8'd0, cfg.spin_stop_time};
			c_s1.lim         <= start_time - {8'd0, cfg.spin_stop_time};
			far_s1           <= {6'd0, dist_in} > cfg.accel_track_span;
			extra_s1         <= dist_in - cfg.accel_track_span[TRACK_W-1:0];
		end
		if (en_s2) begin
			c_s2      <= c_s1;
			far_s2    <= far_s1;
			p_near_s2 <= c_s1.moved * cfg.accel_time_per_track;
			p_span_s2 <= cfg.accel_track_span * cfg.accel_time_per_track;
			p_far_s2  <= extra_s1 * cfg.cruise_time_per_track;
			p_xfer_s2 <= c_s1.block_count * cfg.block_transfer_time;
		end
		if (en_s3) begin
			c_s3    <= c_s2;
			seek_s3 <= far_s2 ? sat32(42'(p_span_s2) + 42'(p_far_s2)) : sat32(42'(p_near_s2));
			xfer_s3 <= 41'(cfg.rotation_latency) + 41'(p_xfer_s2);
		end
		if (en_s4) begin
			c_s4     <= c_s3;
			seek_s4  <= seek_s3;
			acc_a_s4 <= sat32(42'(seek_s3) + 42'(xfer_s3));
			acc_b_s4 <= sat32(42'((cfg.spin_start_time > seek_s3) ? cfg.spin_start_time
				: seek_s3) + 42'(xfer_s3));
		end
		if (en_s5) begin
			c_s5      <= c_s4;
			seek_s5   <= seek_s4;
			acc_a_s5  <= acc_a_s4;
			acc_b_s5  <= acc_b_s4;
			free_a_s5 <= c_s4.start_time + {16'd0, acc_a_s4};
			free_b_s5 <= c_s4.start_time + {16'd0, acc_b_s4};
		end
	end

	always_comb begin
		push_item.start_time   = c_s5.start_time;
		push_item.block_count  = c_s5.block_count;
		push_item.tracks_moved = c_s5.moved;
		push_item.seek_time    = seek_s5;
		push_item.acc_plain    = acc_a_s5;
		push_item.acc_spin     = acc_b_s5;
		push_item.free_plain   = free_a_s5;
		push_item.free_spin    = free_b_s5;
		push_item.lim_ok       = c_s5.lim_ok;
		push_item.lim          = c_s5.lim;
	end

endmodule

// File: src/datm_queue.sv
// ----------------------------------------------------------------------------
// datm_queue
// short request queue between front and back
// ----------------------------------------------------------------------------
module datm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  datm_pkg::req_t push_item,
	output logic           full,
	output logic           valid,
	output datm_pkg::req_t head_item,
	input  logic           pop
);
	import datm_pkg::*;

	req_t              mem [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full      = count_q == (QPTR_W+1)'(QUEUE_DEPTH);
	assign valid     = count_q != '0;
	assign head_item = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// File: src/datm_back.sv
// ----------------------------------------------------------------------------
// datm_back
// spin-up decision, drive-free time, running totals and result register
// ----------------------------------------------------------------------------
module datm_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  datm_pkg::req_t                      q_item,
	output logic                                pop,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [datm_pkg::TIME_W-1:0]         free_time,
	output logic [31:0]                         access_time,
	output logic [31:0]                         seek_time,
	output logic [datm_pkg::TRACK_W-1:0]        tracks_moved,
	output logic                                spin_started,
	output logic [31:0]                         request_total,
	output logic [63:0]                         elapsed_total,
	output logic [63:0]                         seek_total,
	output logic [31:0]                         track_total,
	output logic [47:0]                         block_total,
	output logic [31:0]                         spinup_total,
	output logic signed [63:0]                  idle_total
);
	import datm_pkg::*;

	logic               never_q;
	logic [TIME_W-1:0]  drive_free_q;
	logic               spin;

	logic               v_b1;
	logic               en_b1;
	logic               load;
	logic               spin_b1;
	logic [31:0]        acc_b1, seek_b1;
	logic [TIME_W-1:0]  free_b1;
	logic [TRACK_W-1:0] dist_b1;
	logic [15:0]        blocks_b1;
	logic [TIME_W:0]    idle_b1;

	assign spin   = never_q || (q_item.lim_ok && (q_item.lim > drive_free_q));
	assign load   = v_b1 && (!out_valid || !out_stall);
	assign en_b1  = !v_b1 || load;
	assign pop    = q_valid && en_b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			never_q       <= 1'b1;
			drive_free_q  <= '0;
			v_b1          <= 1'b0;
			out_valid     <= 1'b0;
			request_total <= '0;
			elapsed_total <= '0;
			seek_total    <= '0;
			track_total   <= '0;
			block_total   <= '0;
			spinup_total  <= '0;
			idle_total    <= '0;
		end else begin
			if (en_b1) begin
				v_b1 <= q_valid;
			end
			if (pop) begin
				never_q      <= 1'b0;
				drive_free_q <= spin ? q_item.free_spin : q_item.free_plain;
			end
			if (load) begin
				out_valid     <= 1'b1;
				request_total <= request_total + 32'd1;
				elapsed_total <= elapsed_total + {32'd0, acc_b1};
				seek_total    <= seek_total + {32'd0, seek_b1};
				track_total   <= track_total + {22'd0, dist_b1};
				block_total   <= block_total + {32'd0, blocks_b1};
				spinup_total  <= spinup_total + {31'd0, spin_b1};
				idle_total    <= idle_total + {{15{idle_b1[TIME_W]}}, idle_b1};
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			spin_b1   <= spin;
			acc_b1    <= spin ? q_item.acc_spin : q_item.acc_plain;
			free_b1   <= spin ? q_item.free_spin : q_item.free_plain;
			seek_b1   <= q_item.seek_time;
			dist_b1   <= q_item.tracks_moved;
			blocks_b1 <= q_item.block_count;
			idle_b1   <= {1'b0, q_item.start_time}
				- {1'b0, (never_q ? {TIME_W{1'b0}} : drive_free_q)};
		end
		if (load) begin
			free_time    <= free_b1;
			access_time  <= acc_b1;
			seek_time    <= seek_b1;
			tracks_moved <= dist_b1;
			spin_started <= spin_b1;
		end
	end

endmodule

// File: src/disk_access_time_model_core.sv
// ----------------------------------------------------------------------------
// disk_access_time_model_core
// disk request service-time model: seek, spin-up, rotation and transfer
// ----------------------------------------------------------------------------
// One request is taken per clock cycle while in_stall is low. Five front
// stages work out the track distance, seek time and both access-time
// candidates, a four-entry queue follows, then one back stage makes the
// spin-up decision and one result register adds the running totals. The
// rate is set by the back stage loop, which compares each request with the
// drive-free time left by the request before it, one request per cycle
// while the output is not stalled.
module disk_access_time_model_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic [2:0]         wr_index,
	input  logic [39:0]        wr_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [47:0]        start_time,
	input  logic [9:0]         target_track,
	input  logic [15:0]        block_count,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [47:0]        free_time,
	output logic [31:0]        access_time,
	output logic [31:0]        seek_time,
	output logic [9:0]         tracks_moved,
	output logic               spin_started,
	output logic [31:0]        request_total,
	output logic [63:0]        elapsed_total,
	output logic [63:0]        seek_total,
	output logic [31:0]        track_total,
	output logic [47:0]        block_total,
	output logic [31:0]        spinup_total,
	output logic signed [63:0] idle_total
);
	import datm_pkg::*;

	cfg_t cfg_q;
	logic q_push, q_full, q_valid, q_pop;
	req_t q_in, q_head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.accel_time_per_track  <= RST_ACCEL_TIME;
			cfg_q.accel_track_span      <= RST_ACCEL_SPAN;
			cfg_q.cruise_time_per_track <= RST_CRUISE_TIME;
			cfg_q.spin_stop_time        <= RST_SPIN_STOP;
			cfg_q.spin_start_time       <= RST_SPIN_START;
			cfg_q.rotation_latency      <= RST_ROT_LAT;
			cfg_q.block_transfer_time   <= RST_BLOCK_TIME;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_ACCEL_TIME:  cfg_q.accel_time_per_track  <= wr_data[23:0];
				REG_ACCEL_SPAN:  cfg_q.accel_track_span      <= wr_data[15:0];
				REG_CRUISE_TIME: cfg_q.cruise_time_per_track <= wr_data[23:0];
				REG_SPIN_STOP:   cfg_q.spin_stop_time        <= wr_data[39:0];
				REG_SPIN_START:  cfg_q.spin_start_time       <= wr_data[31:0];
				REG_ROT_LAT:     cfg_q.rotation_latency      <= wr_data[31:0];
				REG_BLOCK_TIME:  cfg_q.block_transfer_time   <= wr_data[23:0];
				default: ;
			endcase
		end
	end

	datm_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.start_time   (start_time),
		.target_track (target_track),
		.block_count  (block_count),
		.push         (q_push),
		.push_item    (q_in),
		.full         (q_full)
	);

	datm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_in),
		.full      (q_full),
		.valid     (q_valid),
		.head_item (q_head),
		.pop       (q_pop)
	);

	datm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (q_valid),
		.q_item        (q_head),
		.pop           (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.free_time     (free_time),
		.access_time   (access_time),
		.seek_time     (seek_time),
		.tracks_moved  (tracks_moved),
		.spin_started  (spin_started),
		.request_total (request_total),
		.elapsed_total (elapsed_total),
		.seek_total    (seek_total),
		.track_total   (track_total),
		.block_total   (block_total),
		.spinup_total  (spinup_total),
		.idle_total    (idle_total)
	);

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("request pushed into full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_pop && !q_valid))
		else $error("request popped from empty queue");

	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && !u_back.load) |=> !out_valid)
		else $error("result register kept a taken request");
`endif

endmodule
